FILE: hw/rtl/egtm_pkg.sv
// ----------------------------------------------------------------------------
// egtm_pkg
// shared widths, register indexes, phase and status codes, and the
// configuration and result types of the echo gate thickness meter
// ----------------------------------------------------------------------------
package egtm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int IDX_W       = 12;
    localparam int FRAME_LEN   = 1 << IDX_W;
    localparam int CNT_W       = IDX_W + 1;
    localparam int SCALE_W     = 24;
    localparam int THICK_W     = 36;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int PHASE_W     = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_METHOD      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_MM     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_G1_LEFT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_G1_RIGHT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_G2_LEFT     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_G2_RIGHT    = 3'd7;

    // register reset values
    localparam logic                          RST_METHOD      = 1'b0;
    localparam logic [SCALE_W-1:0]            RST_HALF_MM     = 24'd54526;
    localparam logic [IDX_W-1:0]              RST_PROBE_START = 12'd400;
    localparam logic signed [SAMPLE_BITS-1:0] RST_THRESHOLD   = 16'sd600;
    localparam logic [IDX_W-1:0]              RST_G1_LEFT     = 12'd20;
    localparam logic [IDX_W-1:0]              RST_G1_RIGHT    = 12'd120;
    localparam logic [IDX_W-1:0]              RST_G2_LEFT     = 12'd140;
    localparam logic [IDX_W-1:0]              RST_G2_RIGHT    = 12'd240;

    localparam logic METHOD_CROSSING = 1'b0;
    localparam logic METHOD_GATES    = 1'b1;

    // zero-crossing phases
    localparam logic [PHASE_W-1:0] PH_SEARCH = 2'd0;
    localparam logic [PHASE_W-1:0] PH_ARMED  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_FOUND  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_GATES   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_THRESH   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_CROSSING = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REVERSED    = 3'd4;

    typedef struct packed {
        logic                          method;
        logic [SCALE_W-1:0]            half_mm_per_sample;
        logic [IDX_W-1:0]              probe_start;
        logic signed [SAMPLE_BITS-1:0] crossing_threshold;
        logic [IDX_W-1:0]              gate1_left;
        logic [IDX_W-1:0]              gate1_right;
        logic [IDX_W-1:0]              gate2_left;
        logic [IDX_W-1:0]              gate2_right;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0]    span;
        logic [STATUS_W-1:0] status;
    } span_res_t;

endpackage

FILE: hw/rtl/egtm_sample_if.sv
// ----------------------------------------------------------------------------
// egtm_sample_if
// valid/ready channel carrying one echo sample and its end-of-frame flag
// ----------------------------------------------------------------------------
interface egtm_sample_if
    import egtm_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

FILE: hw/rtl/egtm_result_if.sv
// ----------------------------------------------------------------------------
// egtm_result_if
// valid/ready channel carrying one thickness result per frame
// ----------------------------------------------------------------------------
interface egtm_result_if
    import egtm_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [THICK_W-1:0]    thickness_q24;
    logic [IDX_W-1:0]      index_span;
    logic [STATUS_W-1:0]   status;

    modport source (output valid, output thickness_q24, output index_span,
                    output status, input ready);
    modport sink   (input valid, input thickness_q24, input index_span,
                    input status, output ready);
endinterface

FILE: hw/rtl/egtm_cfg_regs.sv
// ----------------------------------------------------------------------------
// egtm_cfg_regs
// configuration register file, written by index, no read-back
// ----------------------------------------------------------------------------
module egtm_cfg_regs
    import egtm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_METHOD:      cfg_next.method             = cfg_data[0];
                REG_HALF_MM:     cfg_next.half_mm_per_sample = cfg_data[SCALE_W-1:0];
                REG_PROBE_START: cfg_next.probe_start        = cfg_data[IDX_W-1:0];
                REG_THRESHOLD:   cfg_next.crossing_threshold = cfg_data[SAMPLE_BITS-1:0];
                REG_G1_LEFT:     cfg_next.gate1_left         = cfg_data[IDX_W-1:0];
                REG_G1_RIGHT:    cfg_next.gate1_right        = cfg_data[IDX_W-1:0];
                REG_G2_LEFT:     cfg_next.gate2_left         = cfg_data[IDX_W-1:0];
                REG_G2_RIGHT:    cfg_next.gate2_right        = cfg_data[IDX_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.method             <= RST_METHOD;
            cfg_reg.half_mm_per_sample <= RST_HALF_MM;
            cfg_reg.probe_start        <= RST_PROBE_START;
            cfg_reg.crossing_threshold <= RST_THRESHOLD;
            cfg_reg.gate1_left         <= RST_G1_LEFT;
            cfg_reg.gate1_right        <= RST_G1_RIGHT;
            cfg_reg.gate2_left         <= RST_G2_LEFT;
            cfg_reg.gate2_right        <= RST_G2_RIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/egtm_tracker.sv
// ----------------------------------------------------------------------------
// egtm_tracker
// input register, per-sample crossing and gate peak tracking, and the
// end-of-frame decision into a span/status register
// ----------------------------------------------------------------------------
module egtm_tracker
    import egtm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  cfg_t           cfg,
    egtm_sample_if.sink    sample_ch,
    output logic           res_valid,
    input  logic           res_ready,
    output span_res_t      res
);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic [IDX_W-1:0]              index;
    } gate_t;

    function automatic gate_t gate_feed(gate_t g, logic [IDX_W-1:0] idx,
                                        logic signed [SAMPLE_BITS-1:0] s,
                                        logic [IDX_W-1:0] left,
                                        logic [IDX_W-1:0] right);
        gate_t r;
        r = g;
        if (idx == left)
        begin
            r.value = s;
            r.index = idx;
        end
        else if (idx > left && idx <= right && s > g.value)
        begin
            r.value = s;
            r.index = idx;
        end
        return r;
    endfunction

    // zero padding from index m to the end of the frame
    function automatic logic [IDX_W-1:0] gate_close(gate_t g, logic [CNT_W-1:0] m,
                                                    logic [IDX_W-1:0] left,
                                                    logic [IDX_W-1:0] right);
        logic [IDX_W-1:0] pos;
        pos = g.index;
        if (m <= {1'b0, left})
            pos = left;
        else if (m <= {1'b0, right} && !m[IDX_W] && g.value < 0)
            pos = m[IDX_W-1:0];
        return pos;
    endfunction

    // input register
    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;
    logic                          in_last_reg;

    // frame state
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               ref_sign_reg, ref_sign_next;
    logic [IDX_W-1:0]   cross_idx_reg, cross_idx_next;
    gate_t              g1_reg, g1_next, g2_reg, g2_next;

    // result register
    logic      res_valid_reg;
    span_res_t res_reg;
    span_res_t res_next;

    logic             stall;
    logic             proc;
    logic             active;
    logic [IDX_W-1:0] idx;
    logic             neg;
    logic [IDX_W-1:0] p1_pos, p2_pos;

    // a last sample waits only when both result stages are full
    assign stall           = in_valid_reg && in_last_reg && res_valid_reg && !res_ready;
    assign proc            = in_valid_reg && !stall;
    assign sample_ch.ready = !stall;

    assign active = !cnt_reg[IDX_W];
    assign idx    = cnt_reg[IDX_W-1:0];
    assign neg    = in_sample_reg[SAMPLE_BITS-1];

    always_comb
    begin
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        ref_sign_next  = ref_sign_reg;
        cross_idx_next = cross_idx_reg;
        g1_next        = g1_reg;
        g2_next        = g2_reg;
        if (active)
        begin
            case (phase_reg)
                PH_SEARCH:
                begin
                    if (idx >= cfg.probe_start && in_sample_reg >= cfg.crossing_threshold)
                    begin
                        phase_next    = PH_ARMED;
                        ref_sign_next = neg;
                    end
                end
                PH_ARMED:
                begin
                    if (neg != ref_sign_reg)
                    begin
                        phase_next     = PH_FOUND;
                        cross_idx_next = idx;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
            g1_next  = gate_feed(g1_reg, idx, in_sample_reg, cfg.gate1_left, cfg.gate1_right);
            g2_next  = gate_feed(g2_reg, idx, in_sample_reg, cfg.gate2_left, cfg.gate2_right);
            cnt_next = cnt_reg + 1'b1;
        end
    end

    assign p1_pos = gate_close(g1_next, cnt_next, cfg.gate1_left, cfg.gate1_right);
    assign p2_pos = gate_close(g2_next, cnt_next, cfg.gate2_left, cfg.gate2_right);

    always_comb
    begin
        res_next.span   = '0;
        res_next.status = ST_OK;
        if (cfg.method == METHOD_CROSSING)
        begin
            case (phase_next)
                PH_SEARCH:
                begin
                    // padded zeros can still arm when the threshold is not positive
                    if (cfg.crossing_threshold <= 0 && !cnt_next[IDX_W])
                        res_next.status = ST_NO_CROSSING;
                    else
                        res_next.status = ST_NO_THRESH;
                end
                PH_ARMED:
                begin
                    // negative reference crosses at the first padded zero
                    if (ref_sign_next && !cnt_next[IDX_W])
                        res_next.span = cnt_next[IDX_W-1:0];
                    else
                        res_next.status = ST_NO_CROSSING;
                end
                default:
                begin
                    res_next.span = cross_idx_next;
                end
            endcase
        end
        else
        begin
            if (cfg.gate1_left > cfg.gate1_right || cfg.gate2_left > cfg.gate2_right)
                res_next.status = ST_BAD_GATES;
            else if (p2_pos <= p1_pos)
                res_next.status = ST_REVERSED;
            else
                res_next.span = p2_pos - p1_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            in_valid_reg <= sample_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ch.valid && !stall)
        begin
            in_sample_reg <= sample_ch.sample;
            in_last_reg   <= sample_ch.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            phase_reg     <= PH_SEARCH;
            ref_sign_reg  <= 1'b0;
            cross_idx_reg <= '0;
            g1_reg        <= '0;
            g2_reg        <= '0;
        end
        else if (proc)
        begin
            if (in_last_reg)
            begin
                cnt_reg       <= '0;
                phase_reg     <= PH_SEARCH;
                ref_sign_reg  <= 1'b0;
                cross_idx_reg <= '0;
                g1_reg        <= '0;
                g2_reg        <= '0;
            end
            else
            begin
                cnt_reg       <= cnt_next;
                phase_reg     <= phase_next;
                ref_sign_reg  <= ref_sign_next;
                cross_idx_reg <= cross_idx_next;
                g1_reg        <= g1_next;
                g2_reg        <= g2_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (proc && in_last_reg)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && in_last_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: hw/rtl/egtm_scaler.sv
// ----------------------------------------------------------------------------
// egtm_scaler
// scales the index span by the half-millimetre-per-sample factor into the
// output register
// ----------------------------------------------------------------------------
module egtm_scaler
    import egtm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [SCALE_W-1:0] half_mm_per_sample,
    input  logic          res_valid,
    output logic          res_ready,
    input  span_res_t     res,
    egtm_result_if.source result_ch
);

    logic                out_valid_reg;
    logic [THICK_W-1:0]  thick_reg;
    logic [THICK_W-1:0]  thick_next;
    logic [IDX_W-1:0]    span_reg;
    logic [STATUS_W-1:0] status_reg;

    // 12 x 24 product fits the 36-bit output exactly
    assign thick_next = THICK_W'(res.span) * THICK_W'(half_mm_per_sample);
    assign res_ready  = !out_valid_reg || result_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            thick_reg  <= thick_next;
            span_reg   <= res.span;
            status_reg <= res.status;
        end
    end

    assign result_ch.valid         = out_valid_reg;
    assign result_ch.thickness_q24 = thick_reg;
    assign result_ch.index_span    = span_reg;
    assign result_ch.status        = status_reg;

endmodule

FILE: hw/rtl/echo_gate_thickness_meter_core.sv
// ----------------------------------------------------------------------------
// echo_gate_thickness_meter_core
// ultrasonic time-of-flight thickness gauge over a stream of echo samples
// ----------------------------------------------------------------------------
// Takes one echo sample per clock on sample_ch and returns one result per
// frame on result_ch; result_ch.valid rises once the sample marked last has
// passed the input register, the span register and the output register.
// Every sample updates the crossing search and both gate peak trackers,
// so the sustained rate is one sample per clock; sample_ch.ready drops
// only while a sample marked last waits in the input register, a finished
// result fills both the span register and the output register, and
// result_ch is stalled. Samples past index 4095 are ignored until last.
// thickness_q24 is index_span times half_mm_per_sample; on any nonzero
// status both are zero. Configuration writes take effect on the next clock
// and should be made between frames.
module echo_gate_thickness_meter_core
    import egtm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    egtm_sample_if.sink           sample_ch,
    egtm_result_if.source         result_ch
);

    cfg_t      cfg;
    logic      res_valid;
    logic      res_ready;
    span_res_t res;

    egtm_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    egtm_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .sample_ch (sample_ch),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    egtm_scaler u_scaler (
        .clk                (clk),
        .rst_n              (rst_n),
        .half_mm_per_sample (cfg.half_mm_per_sample),
        .res_valid          (res_valid),
        .res_ready          (res_ready),
        .res                (res),
        .result_ch          (result_ch)
    );

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// streams echo frames into the meter with random gaps and output stalls, and
// checks each frame result against an in-bench gauge model or a scripted one
// ----------------------------------------------------------------------------
module testbench;
    import egtm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_BEATS = 535;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [THICK_W-1:0]  thick;
        logic [IDX_W-1:0]    span;
        logic [STATUS_W-1:0] status;
    } meas_t;

    typedef enum logic {STEP_WRITE, STEP_BEAT} step_e;

    typedef struct packed {
        step_e                         kind;
        logic [CFG_IDX_W-1:0]          reg_sel;
        logic [CFG_DATA_W-1:0]         wdata;
        logic signed [SAMPLE_BITS-1:0] smp;
        logic                          fin;
        logic                          typed;
        meas_t                         want;
    } row_t;

    localparam meas_t NO_MEAS        = '0;
    localparam meas_t MEAS_BAD_GATES = '{36'd0, 12'd0, ST_BAD_GATES};
    localparam meas_t MEAS_NO_THRESH = '{36'd0, 12'd0, ST_NO_THRESH};
    localparam meas_t MEAS_NO_CROSS  = '{36'd0, 12'd0, ST_NO_CROSSING};
    localparam meas_t MEAS_REVERSED  = '{36'd0, 12'd0, ST_REVERSED};

    localparam int SCRIPT_ROWS = 30;
    localparam row_t SCRIPT [SCRIPT_ROWS] = '{
        '{STEP_BEAT,  REG_METHOD,      24'd0,       16'sh8000, 1'b1, 1'b1, MEAS_NO_THRESH},
        '{STEP_WRITE, REG_PROBE_START, 24'd0,       16'sd0,    1'b0, 1'b0, NO_MEAS},
        '{STEP_WRITE, REG_THRESHOLD,   24'd100,     16'sd0,    1'b0, 1'b0, NO_MEAS},
        '{STEP_BEAT,  REG_METHOD,      24'd0,       16'sd200,  1'b0, 1'b0, NO_MEAS},
        '{STEP_BEAT,  REG_METHOD,      24'd0,       -16'sd1,   1'b0, 1'b0, NO_MEAS},
        '{STEP_BEAT,  REG_METHOD,      24'd0,       16'sd0,    1'b1, 1'b0, NO_MEAS},
        '{STEP_BEAT,  REG_METHOD,      24'd0,       16'sh7FFF, 1'b1, 1'b1, MEAS_NO_CROSS},
        '{STEP_WRITE, REG_THRESHOLD,   24'h008000,  16'sd0,    1'b0, 1'b0, NO_MEAS},
        '{STEP_BEAT,  REG_METHOD,      24'd0,       -16'sd5,   1'b1, 1'b0, NO_MEAS},
        '{STEP_WRITE, REG_PROBE_START, 24'd4095,    16'sd0,    1'b0, 1'b0, NO_MEAS},
        '{STEP_WRITE, REG_THRESHOLD,   24'd0,       16'sd0,    1'b0, 1'b0, NO_MEAS},
        '{STEP_BEAT,  REG_METHOD,      24'd0,       16'sd0,    1'b1, 1'b1, MEAS_NO_CROSS},
        '{STEP_WRITE, REG_HALF_MM,     24'hFFFFFF,  16'sd0,    1'b0, 1'b0, NO_MEAS},
        '{STEP_WRITE, REG_METHOD,      24'd1,       16'sd0,    1'b0, 1'b0, NO_MEAS},
        '{STEP_BEAT,  REG_METHOD,      24'd0,       16'sd7,    1'b1, 1'b0, NO_MEAS},
        '{STEP_WRITE, REG_G1_LEFT,     24'd4095,    16'sd0,    1'b0, 1'b0, NO_MEAS},
        '{STEP_BEAT,  REG_METHOD,      24'd0,       16'sd1,    1'b1, 1'b1, MEAS_BAD_GATES},
        '{STEP_WRITE, REG_G1_LEFT,     24'd0,       16'sd0,    1'b0, 1'b0, NO_MEAS},
        '{STEP_WRITE, REG_G1_RIGHT,    24'd0,       16'sd0,    1'b0, 1'b0, NO_MEAS},
        '{STEP_WRITE, REG_G2_LEFT,     24'd4095,    16'sd0,    1'b0, 1'b0, NO_MEAS},
        '{STEP_WRITE, REG_G2_RIGHT,    24'd4095,    16'sd0,    1'b0, 1'b0, NO_MEAS},
        '{STEP_BEAT,  REG_METHOD,      24'd0,       16'sh8000, 1'b1, 1'b0, NO_MEAS},
        '{STEP_WRITE, REG_G2_LEFT,     24'd0,       16'sd0,    1'b0, 1'b0, NO_MEAS},
        '{STEP_WRITE, REG_G2_RIGHT,    24'd0,       16'sd0,    1'b0, 1'b0, NO_MEAS},
        '{STEP_BEAT,  REG_METHOD,      24'd0,       16'sd5,    1'b1, 1'b1, MEAS_REVERSED},
        '{STEP_WRITE, REG_G2_LEFT,     24'd1,       16'sd0,    1'b0, 1'b0, NO_MEAS},
        '{STEP_WRITE, REG_G2_RIGHT,    24'd9,       16'sd0,    1'b0, 1'b0, NO_MEAS},
        '{STEP_BEAT,  REG_METHOD,      24'd0,       16'sd4,    1'b0, 1'b0, NO_MEAS},
        '{STEP_BEAT,  REG_METHOD,      24'd0,       -16'sd9,   1'b0, 1'b0, NO_MEAS},
        '{STEP_BEAT,  REG_METHOD,      24'd0,       -16'sd2,   1'b1, 1'b0, NO_MEAS}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    egtm_sample_if sample_bus ();
    egtm_result_if result_bus ();

    echo_gate_thickness_meter_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_ch (sample_bus),
        .result_ch (result_bus)
    );

    // gauge model state
    cfg_t             gauge_regs;
    logic [CNT_W-1:0] seen_cnt;
    logic [PHASE_W-1:0] arm_phase;
    logic             arm_neg;
    logic [IDX_W-1:0] cross_at;
    int               pk1_val, pk1_at, pk2_val, pk2_at;

    meas_t thickness_due [$];
    meas_t oldest;
    int    fault_cnt;
    int    cycle_cnt;
    int    sink_hold;
    bit    src_calm;
    bit    sink_calm;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic int idle_len(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void frame_clear();
        seen_cnt  = '0;
        arm_phase = PH_SEARCH;
        arm_neg   = 1'b0;
        cross_at  = '0;
        pk1_val   = 0;
        pk1_at    = 0;
        pk2_val   = 0;
        pk2_at    = 0;
    endfunction

    function automatic void peak_track(input int idx, input int s, input int left,
                                       input int right, inout int val, inout int pos);
        if (idx == left)
        begin
            val = s;
            pos = idx;
        end
        else if (idx > left && idx <= right && s > val)
        begin
            val = s;
            pos = idx;
        end
    endfunction

    // unreceived samples up to the frame end read as zero
    function automatic void peak_pad(input int m, input int left, input int right,
                                     inout int val, inout int pos);
        if (m <= left)
        begin
            val = 0;
            pos = left;
        end
        else if (m <= right && m < FRAME_LEN && val < 0)
        begin
            val = 0;
            pos = m;
        end
    endfunction

    function automatic bit gauge_step(input logic signed [SAMPLE_BITS-1:0] smp,
                                      input logic fin, output meas_t res);
        int s, idx, m, first, thr, probe, g1l, g1r, g2l, g2r;
        bit neg;
        logic [IDX_W-1:0]    span;
        logic [STATUS_W-1:0] st;
        res   = '0;
        s     = int'(smp);
        thr   = int'(gauge_regs.crossing_threshold);
        probe = int'(gauge_regs.probe_start);
        g1l   = int'(gauge_regs.gate1_left);
        g1r   = int'(gauge_regs.gate1_right);
        g2l   = int'(gauge_regs.gate2_left);
        g2r   = int'(gauge_regs.gate2_right);
        if (seen_cnt < FRAME_LEN)
        begin
            idx = int'(seen_cnt);
            neg = s < 0;
            if (arm_phase == PH_SEARCH)
            begin
                if (idx >= probe && s >= thr)
                begin
                    arm_phase = PH_ARMED;
                    arm_neg   = neg;
                end
            end
            else if (arm_phase == PH_ARMED)
            begin
                if (neg != arm_neg)
                begin
                    arm_phase = PH_FOUND;
                    cross_at  = IDX_W'(idx);
                end
            end
            peak_track(idx, s, g1l, g1r, pk1_val, pk1_at);
            peak_track(idx, s, g2l, g2r, pk2_val, pk2_at);
            seen_cnt = CNT_W'(idx + 1);
        end
        if (!fin)
            return 1'b0;

        m    = int'(seen_cnt);
        span = '0;
        st   = ST_OK;
        if (gauge_regs.method == METHOD_CROSSING)
        begin
            if (arm_phase == PH_SEARCH)
            begin
                first = (m > probe) ? m : probe;
                st = (thr <= 0 && first < FRAME_LEN) ? ST_NO_CROSSING : ST_NO_THRESH;
            end
            else if (arm_phase == PH_ARMED)
            begin
                // a negative arming sample swings back to the zero padding
                if (arm_neg && m < FRAME_LEN)
                    span = IDX_W'(m);
                else
                    st = ST_NO_CROSSING;
            end
            else
                span = cross_at;
        end
        else
        begin
            if (g1l > g1r || g2l > g2r || g1r >= FRAME_LEN || g2r >= FRAME_LEN)
                st = ST_BAD_GATES;
            else
            begin
                peak_pad(m, g1l, g1r, pk1_val, pk1_at);
                peak_pad(m, g2l, g2r, pk2_val, pk2_at);
                if (pk2_at <= pk1_at)
                    st = ST_REVERSED;
                else
                    span = IDX_W'(pk2_at - pk1_at);
            end
        end
        if (st != ST_OK)
            span = '0;
        res.span   = span;
        res.status = st;
        res.thick  = span * gauge_regs.half_mm_per_sample;
        frame_clear();
        return 1'b1;
    endfunction

    // wait until every result is back and the pipeline is empty
    task automatic settle();
        sample_bus.valid <= 1'b0;
        while (thickness_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] sel,
                             input logic [CFG_DATA_W-1:0] d);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= d;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (sel)
            REG_METHOD:      gauge_regs.method             = d[0];
            REG_HALF_MM:     gauge_regs.half_mm_per_sample = d[SCALE_W-1:0];
            REG_PROBE_START: gauge_regs.probe_start        = d[IDX_W-1:0];
            REG_THRESHOLD:   gauge_regs.crossing_threshold = d[SAMPLE_BITS-1:0];
            REG_G1_LEFT:     gauge_regs.gate1_left         = d[IDX_W-1:0];
            REG_G1_RIGHT:    gauge_regs.gate1_right        = d[IDX_W-1:0];
            REG_G2_LEFT:     gauge_regs.gate2_left         = d[IDX_W-1:0];
            REG_G2_RIGHT:    gauge_regs.gate2_right        = d[IDX_W-1:0];
            default:         ;
        endcase
        @(negedge clk);
    endtask

    // unused upper data bits carry junk, the block keeps only the field width
    task automatic apply_config(input cfg_t c);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        cfg_write(REG_METHOD, {junk[CFG_DATA_W-1:1], c.method});
        cfg_write(REG_HALF_MM, c.half_mm_per_sample);
        cfg_write(REG_PROBE_START, {junk[CFG_DATA_W-1:IDX_W], c.probe_start});
        cfg_write(REG_THRESHOLD, {junk[CFG_DATA_W-1:SAMPLE_BITS], c.crossing_threshold});
        junk = CFG_DATA_W'($urandom);
        cfg_write(REG_G1_LEFT, {junk[CFG_DATA_W-1:IDX_W], c.gate1_left});
        cfg_write(REG_G1_RIGHT, {junk[IDX_W-1:0], c.gate1_right});
        cfg_write(REG_G2_LEFT, {junk[CFG_DATA_W-1:IDX_W], c.gate2_left});
        cfg_write(REG_G2_RIGHT, {junk[IDX_W-1:0], c.gate2_right});
    endtask

    task automatic pick_config(output cfg_t c);
        int v;
        c.method = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0:       c.half_mm_per_sample = '0;
            1:       c.half_mm_per_sample = '1;
            default: c.half_mm_per_sample = SCALE_W'($urandom);
        endcase
        if ($urandom_range(0, 9) != 0)
            c.probe_start = IDX_W'($urandom_range(0, 40));
        else
            c.probe_start = IDX_W'($urandom);
        case ($urandom_range(0, 9))
            0:       c.crossing_threshold = 16'sh8000;
            1:       c.crossing_threshold = 16'sh7FFF;
            2:       c.crossing_threshold = 16'sd0;
            default:
            begin
                v = int'($urandom_range(0, 12000)) - 2000;
                c.crossing_threshold = SAMPLE_BITS'(v);
            end
        endcase
        c.gate1_left  = IDX_W'($urandom_range(0, 20));
        c.gate1_right = c.gate1_left + IDX_W'($urandom_range(0, 20));
        c.gate2_left  = IDX_W'($urandom_range(0, 40));
        c.gate2_right = c.gate2_left + IDX_W'($urandom_range(0, 30));
        // now and then a wild gate edge
        case ($urandom_range(0, 19))
            0:       c.gate1_left  = IDX_W'($urandom);
            1:       c.gate1_right = IDX_W'($urandom);
            2:       c.gate2_left  = IDX_W'($urandom);
            3:       c.gate2_right = IDX_W'($urandom);
            default: ;
        endcase
    endtask

    task automatic send_beat(input logic signed [SAMPLE_BITS-1:0] smp, input logic fin,
                             input logic typed, input meas_t typed_res);
        meas_t calc;
        int    gap;
        sample_bus.sample <= smp;
        sample_bus.last   <= fin;
        sample_bus.valid  <= 1'b1;
        do
            @(posedge clk);
        while (sample_bus.ready !== 1'b1);
        if (gauge_step(smp, fin, calc))
            thickness_due.push_back(typed ? typed_res : calc);
        @(negedge clk);
        gap = idle_len(src_calm);
        if (gap > 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_frame(input int len);
        int i, style, amp, hp, onset, v;
        logic signed [SAMPLE_BITS-1:0] smp;
        style = $urandom_range(0, 3);
        amp   = $urandom_range(0, 32767);
        hp    = $urandom_range(1, 6);
        onset = $urandom_range(0, len);
        for (i = 0; i < len; i++)
        begin
            case (style)
                0: v = $signed(SAMPLE_BITS'($urandom));
                1:
                begin
                    // quiet lead-in, then a square burst of the echo
                    v = int'($urandom_range(0, 100)) - 50;
                    if (i >= onset)
                        v += (((i - onset) / hp) % 2 != 0) ? -amp : amp;
                end
                2: v = int'($urandom_range(0, 400)) - 200;
                default:
                    case ($urandom_range(0, 4))
                        0:       v = -32768;
                        1:       v = 32767;
                        2:       v = 0;
                        3:       v = -1;
                        default: v = $signed(SAMPLE_BITS'($urandom));
                    endcase
            endcase
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            smp = SAMPLE_BITS'(v);
            send_beat(smp, i == len - 1, 1'b0, NO_MEAS);
        end
    endtask

    initial
    begin
        result_bus.ready = 1'b0;
        sink_hold = 0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                result_bus.ready <= 1'b0;
                sink_hold--;
            end
            else
            begin
                result_bus.ready <= 1'b1;
                sink_hold = idle_len(sink_calm);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
        begin
            if (thickness_due.size() == 0)
            begin
                fault_cnt++;
                if (fault_cnt <= 10)
                    $display("result with none expected: thickness %0h span %0d status %0d",
                             result_bus.thickness_q24, result_bus.index_span,
                             result_bus.status);
            end
            else
            begin
                oldest = thickness_due.pop_front();
                if (result_bus.thickness_q24 !== oldest.thick ||
                    result_bus.index_span !== oldest.span ||
                    result_bus.status !== oldest.status)
                begin
                    fault_cnt++;
                    if (fault_cnt <= 10)
                        $display("mismatch: thickness %0h/%0h span %0d/%0d status %0d/%0d",
                                 oldest.thick, result_bus.thickness_q24,
                                 oldest.span, result_bus.index_span,
                                 oldest.status, result_bus.status);
                end
            end
        end
    end

    initial
    begin
        int   k, random_beats, nframes, len;
        cfg_t phase_cfg;
        fault_cnt         = 0;
        cycle_cnt         = 0;
        src_calm          = 1'b0;
        sink_calm         = 1'b0;
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        sample_bus.valid  = 1'b0;
        sample_bus.sample = '0;
        sample_bus.last   = 1'b0;
        gauge_regs = '{RST_METHOD, RST_HALF_MM, RST_PROBE_START, RST_THRESHOLD,
                       RST_G1_LEFT, RST_G1_RIGHT, RST_G2_LEFT, RST_G2_RIGHT};
        frame_clear();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (k = 0; k < SCRIPT_ROWS; k++)
        begin
            if (SCRIPT[k].kind == STEP_WRITE)
                cfg_write(SCRIPT[k].reg_sel, SCRIPT[k].wdata);
            else
                send_beat(SCRIPT[k].smp, SCRIPT[k].fin, SCRIPT[k].typed, SCRIPT[k].want);
        end

        random_beats = 0;
        while (random_beats < RANDOM_BEATS)
        begin
            pick_config(phase_cfg);
            apply_config(phase_cfg);
            src_calm  = ($urandom_range(0, 3) == 0);
            sink_calm = ($urandom_range(0, 3) == 0);
            nframes   = $urandom_range(1, 4);
            repeat (nframes)
            begin
                len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 32)
                                                 : $urandom_range(33, 300);
                send_frame(len);
                random_beats += len;
                if ($urandom_range(0, 9) == 0)
                    settle();
            end
        end

        src_calm  = 1'b0;
        sink_calm = 1'b0;
        settle();
        repeat (10) @(negedge clk);
        if (fault_cnt == 0 && thickness_due.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
